// ===== rtl/lir_pkg.sv =====
package lir_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int FRAME_COUNT_BITS = 26;
    localparam int MAX_RUN          = 16;
    localparam int OUT_BITS         = 27;
    localparam int FRAC_BITS        = 16;
    localparam int POS_BITS         = FRAME_COUNT_BITS + FRAC_BITS;
    localparam int STEP_BITS        = 24;
    localparam int GAIN_BITS        = 16;
    localparam int GAIN_FRAC_BITS   = 12;
    localparam int RUN_BITS         = $clog2(MAX_RUN + 1);

    // shared multiplier: sample-sized operand times fraction or gain
    localparam int MUL_A_BITS  = SAMPLE_BITS + 2;
    localparam int MUL_B_BITS  = ((FRAC_BITS > GAIN_BITS) ? FRAC_BITS : GAIN_BITS) + 1;
    localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int SCALED_BITS = MUL_P_BITS - GAIN_FRAC_BITS;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = FRAME_COUNT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_FRAMES = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MONO_MODE     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO_SOURCE = 3'd4;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 24'd65536;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET       = 16'd20480;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_DL,
        ST_MUL_DR,
        ST_MUL_GL,
        ST_MUL_GR,
        ST_MUL_END,
        ST_FL_GL,
        ST_FL_GR,
        ST_FL_END,
        ST_EMIT,
        ST_PUSH,
        ST_FINISH
    } lir_state_t;

endpackage

// ===== rtl/lir_in_if.sv =====
interface lir_in_if
    import lir_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          final_source;

    modport source (output valid, output left_sample, output right_sample,
                    output final_source, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input final_source, output ready);
endinterface

// ===== rtl/lir_out_if.sv =====
interface lir_out_if
    import lir_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] left_out;
    logic signed [OUT_BITS-1:0] right_out;
    logic                       run_last;
    logic                       frame_final;

    modport source (output valid, output left_out, output right_out,
                    output run_last, output frame_final, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input run_last, input frame_final, output ready);
endinterface

// ===== rtl/lir_cfg_if.sv =====
interface lir_cfg_if
    import lir_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/linear_interp_resampler_top.sv =====
// channel   role    payload
// samples   sink    left_sample, right_sample, final_source
// frames    source  left_out, right_out, run_last, frame_final
// cfg       sink    index, data (register write, always ready)
//
// each source frame is taken, checked, and then produces n interpolated outputs
// (0..16), each through the multiply, emit and push steps; a final frame also
// adds m flush copies. every product goes through the single 26x17 multiplier,
// four per interpolated output.
// the last result sits in the output register while the next frame is taken.
// reset is asynchronous, active low; no clearing pass is needed.
// a stalled output holds the sequencer in its push step; nothing is dropped.
module linear_interp_resampler_top
    import lir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lir_in_if.sink   samples,
    lir_out_if.source frames,
    lir_cfg_if.sink  cfg
);

    localparam int VAL_BITS = MUL_A_BITS;
    localparam int MIX_BITS = SCALED_BITS + 1;

    localparam logic signed [SCALED_BITS-1:0] SAT_HI =
        SCALED_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [SCALED_BITS-1:0] SAT_LO =
        SCALED_BITS'(-(64'sd1 <<< (OUT_BITS - 1)));

    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [SCALED_BITS-1:0] x);
        logic signed [OUT_BITS-1:0] r;
        if (x > SAT_HI)
            r = SAT_HI[OUT_BITS-1:0];
        else if (x < SAT_LO)
            r = SAT_LO[OUT_BITS-1:0];
        else
            r = x[OUT_BITS-1:0];
        return r;
    endfunction

    // configuration registers
    logic [STEP_BITS-1:0]        phase_step_reg;
    logic [FRAME_COUNT_BITS-1:0] output_frames_reg;
    logic [GAIN_BITS-1:0]        gain_reg;
    logic                        mono_mode_reg;
    logic                        stereo_source_reg;

    // stream state
    logic [POS_BITS-1:0]           pos_reg;
    logic [FRAME_COUNT_BITS-1:0]   idx_reg;
    logic [FRAME_COUNT_BITS-1:0]   emitted_reg;
    logic signed [SAMPLE_BITS-1:0] prev_l_reg;
    logic signed [SAMPLE_BITS-1:0] prev_r_reg;

    // per-frame working registers
    logic signed [SAMPLE_BITS-1:0] cur_l_reg;
    logic signed [SAMPLE_BITS-1:0] cur_r_reg;
    logic                          fin_reg;
    logic                          flush_reg;
    logic [RUN_BITS-1:0]           run_reg;
    logic signed [MUL_P_BITS-1:0]  prod_reg;
    logic signed [VAL_BITS-1:0]    vl_reg;
    logic signed [VAL_BITS-1:0]    vr_reg;
    logic signed [SCALED_BITS-1:0] sl_reg;
    logic signed [SCALED_BITS-1:0] sr_reg;
    logic signed [OUT_BITS-1:0]    hold_l_reg;
    logic signed [OUT_BITS-1:0]    hold_r_reg;
    logic                          hold_ff_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [OUT_BITS-1:0]    out_l_reg;
    logic signed [OUT_BITS-1:0]    out_r_reg;
    logic                          out_last_reg;
    logic                          out_final_reg;

    lir_state_t state_reg;
    lir_state_t state_next;

    // shared multiplier
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] mul_p;
    logic signed [MUL_P_BITS-1:0] prod_frac_shift;
    logic signed [MUL_P_BITS-1:0] prod_gain_shift;
    logic signed [MUL_B_BITS-1:0] frac_op;
    logic signed [MUL_B_BITS-1:0] gain_op;

    // emit path
    logic signed [MIX_BITS-1:0]   mix_sum;
    logic signed [MIX_BITS-1:0]   mix_half;
    logic signed [OUT_BITS-1:0]   emit_l;
    logic signed [OUT_BITS-1:0]   emit_r;
    logic [FRAME_COUNT_BITS-1:0]  emitted_inc;

    // loop control
    logic loop_ok;
    logic interp_ok;
    logic more;
    logic out_free;
    logic push;
    logic take_in;
    logic take_cfg;
    logic signed [SAMPLE_BITS-1:0] in_r_sel;

    assign take_in  = samples.valid && samples.ready;
    assign take_cfg = cfg.valid && cfg.ready;
    assign in_r_sel = stereo_source_reg ? samples.right_sample : samples.left_sample;
    assign out_free = !out_valid_reg || frames.ready;

    assign frac_op = signed'(MUL_B_BITS'(pos_reg[FRAC_BITS-1:0]));
    assign gain_op = signed'(MUL_B_BITS'(gain_reg));
    assign mul_p   = mul_a * mul_b;

    assign prod_frac_shift = prod_reg >>> FRAC_BITS;
    assign prod_gain_shift = prod_reg >>> GAIN_FRAC_BITS;

    assign mix_sum     = MIX_BITS'(sl_reg) + MIX_BITS'(sr_reg);
    assign mix_half    = mix_sum >>> 1;
    assign emit_l      = mono_mode_reg ? sat_out(mix_half[SCALED_BITS-1:0]) : sat_out(sl_reg);
    assign emit_r      = mono_mode_reg ? '0 : sat_out(sr_reg);
    assign emitted_inc = emitted_reg + 1'b1;

    // continuation tests read the already updated counters
    assign loop_ok   = (run_reg < RUN_BITS'(MAX_RUN)) && (emitted_reg < output_frames_reg);
    assign interp_ok = loop_ok && !flush_reg && (idx_reg != '0)
                       && (pos_reg[POS_BITS-1:FRAC_BITS] < idx_reg);
    assign more      = interp_ok || ((fin_reg || flush_reg) && loop_ok);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (interp_ok)
                    state_next = ST_MUL_DL;
                else if (fin_reg && loop_ok)
                    state_next = ST_FL_GL;
                else
                    state_next = ST_FINISH;
            end
            ST_MUL_DL:  state_next = ST_MUL_DR;
            ST_MUL_DR:  state_next = ST_MUL_GL;
            ST_MUL_GL:  state_next = ST_MUL_GR;
            ST_MUL_GR:  state_next = ST_MUL_END;
            ST_MUL_END: state_next = ST_EMIT;
            ST_FL_GL:   state_next = ST_FL_GR;
            ST_FL_GR:   state_next = ST_FL_END;
            ST_FL_END:  state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (out_free)
                begin
                    if (interp_ok)
                        state_next = ST_MUL_DL;
                    else if (more && flush_reg)
                        state_next = ST_EMIT;
                    else if (more)
                        state_next = ST_FL_GL;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands and handshakes
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        push  = 1'b0;
        unique case (state_reg)
            ST_MUL_DL:
            begin
                mul_a = MUL_A_BITS'(cur_l_reg) - MUL_A_BITS'(prev_l_reg);
                mul_b = frac_op;
            end
            ST_MUL_DR:
            begin
                mul_a = MUL_A_BITS'(cur_r_reg) - MUL_A_BITS'(prev_r_reg);
                mul_b = frac_op;
            end
            ST_MUL_GL:
            begin
                mul_a = vl_reg;
                mul_b = gain_op;
            end
            ST_MUL_GR:
            begin
                mul_a = vr_reg;
                mul_b = gain_op;
            end
            ST_FL_GL:
            begin
                mul_a = MUL_A_BITS'(cur_l_reg);
                mul_b = gain_op;
            end
            ST_FL_GR:
            begin
                mul_a = MUL_A_BITS'(cur_r_reg);
                mul_b = gain_op;
            end
            ST_PUSH:
            begin
                push = out_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign frames.valid       = out_valid_reg;
    assign frames.left_out    = out_l_reg;
    assign frames.right_out   = out_r_reg;
    assign frames.run_last    = out_last_reg;
    assign frames.frame_final = out_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= PHASE_STEP_RESET;
            output_frames_reg <= '0;
            gain_reg          <= GAIN_RESET;
            mono_mode_reg     <= 1'b0;
            stereo_source_reg <= 1'b1;
        end
        else if (take_cfg)
        begin
            unique case (cfg.index)
                CFG_PHASE_STEP:    phase_step_reg    <= cfg.data[STEP_BITS-1:0];
                CFG_OUTPUT_FRAMES: output_frames_reg <= cfg.data[FRAME_COUNT_BITS-1:0];
                CFG_GAIN:          gain_reg          <= cfg.data[GAIN_BITS-1:0];
                CFG_MONO_MODE:     mono_mode_reg     <= cfg.data[0];
                CFG_STEREO_SOURCE: stereo_source_reg <= cfg.data[0];
                default:           phase_step_reg    <= phase_step_reg;
            endcase
        end
    end

    // stream state and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            idx_reg     <= '0;
            emitted_reg <= '0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            fin_reg     <= 1'b0;
            flush_reg   <= 1'b0;
            run_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take_in)
                    begin
                        fin_reg   <= samples.final_source;
                        flush_reg <= 1'b0;
                        run_reg   <= '0;
                        // a mono source keeps both history channels equal
                        if (!stereo_source_reg)
                            prev_r_reg <= prev_l_reg;
                    end
                end
                ST_FL_GL:
                begin
                    flush_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    emitted_reg <= emitted_inc;
                    run_reg     <= run_reg + 1'b1;
                    if (!flush_reg)
                        pos_reg <= pos_reg + POS_BITS'(phase_step_reg);
                end
                ST_FINISH:
                begin
                    if (fin_reg)
                    begin
                        // end of sample: start over for the next one
                        pos_reg     <= '0;
                        idx_reg     <= '0;
                        emitted_reg <= '0;
                        prev_l_reg  <= '0;
                        prev_r_reg  <= '0;
                    end
                    else
                    begin
                        prev_l_reg <= cur_l_reg;
                        prev_r_reg <= cur_r_reg;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    run_reg <= run_reg;
                end
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (take_in)
        begin
            cur_l_reg <= samples.left_sample;
            cur_r_reg <= in_r_sel;
        end
        unique case (state_reg)
            ST_MUL_DR:
            begin
                vl_reg <= VAL_BITS'(prev_l_reg) + VAL_BITS'(prod_frac_shift);
            end
            ST_MUL_GL:
            begin
                vr_reg <= VAL_BITS'(prev_r_reg) + VAL_BITS'(prod_frac_shift);
            end
            ST_MUL_GR, ST_FL_GR:
            begin
                sl_reg <= SCALED_BITS'(prod_gain_shift);
            end
            ST_MUL_END, ST_FL_END:
            begin
                sr_reg <= SCALED_BITS'(prod_gain_shift);
            end
            ST_EMIT:
            begin
                hold_l_reg  <= emit_l;
                hold_r_reg  <= emit_r;
                hold_ff_reg <= (emitted_inc == output_frames_reg);
            end
            default:
            begin
                hold_ff_reg <= hold_ff_reg;
            end
        endcase
    end

    // output register: one result waits here while the next one is built
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (frames.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_l_reg     <= hold_l_reg;
            out_r_reg     <= hold_r_reg;
            out_last_reg  <= !more;
            // a final frame also marks its last result as the sample's end
            out_final_reg <= hold_ff_reg || (fin_reg && !more);
        end
    end

endmodule
